// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the i2c register access block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising clk edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
// ---------------------------------------------------------------------------
// i2cm_pkg
// types and codes shared by the i2c register access sequencer
// ---------------------------------------------------------------------------
package i2cm_pkg;

  localparam int RECOVERY_PULSES_DEF = 9;

  // commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_BURST = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ADDRW_NAK = 3'd1;
  localparam logic [2:0] ST_REG_NAK   = 3'd2;
  localparam logic [2:0] ST_ADDRR_NAK = 3'd3;
  localparam logic [2:0] ST_DATA_NAK  = 3'd4;
  localparam logic [2:0] ST_ZERO_LEN  = 3'd5;

  // sequencer phases
  localparam logic [4:0] PH_IDLE        = 5'd0;
  localparam logic [4:0] PH_START       = 5'd1;
  localparam logic [4:0] PH_TX_ADDRW    = 5'd2;
  localparam logic [4:0] PH_ACK_ADDRW   = 5'd3;
  localparam logic [4:0] PH_TX_REG      = 5'd4;
  localparam logic [4:0] PH_ACK_REG     = 5'd5;
  localparam logic [4:0] PH_TX_DATA     = 5'd6;
  localparam logic [4:0] PH_ACK_DATA    = 5'd7;
  localparam logic [4:0] PH_RSTART      = 5'd8;
  localparam logic [4:0] PH_TX_ADDRR    = 5'd9;
  localparam logic [4:0] PH_ACK_ADDRR   = 5'd10;
  localparam logic [4:0] PH_RX          = 5'd11;
  localparam logic [4:0] PH_TX_ACK      = 5'd12;
  localparam logic [4:0] PH_STOP        = 5'd13;
  localparam logic [4:0] PH_RECOV       = 5'd14;
  localparam logic [4:0] PH_RECOV_START = 5'd15;
  localparam logic [4:0] PH_RECOV_STOP  = 5'd16;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] dev_addr;
    logic [7:0] reg_ptr;
    logic [7:0] wr_data;
    logic [7:0] burst_len;
    logic       final_ack_bit;
    logic       sda_in;
  } i2cm_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_last;
    logic       done_res;
    logic [2:0] status;
    logic       busy_res;
  } i2cm_result_t;

endpackage

// ===== rtl/i2cm_seq.sv =====
// ---------------------------------------------------------------------------
// i2cm_seq
// bus sequencer state and one-tick next-state logic
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cm_seq import i2cm_pkg::*; #(
  parameter int RECOVERY_PULSES = RECOVERY_PULSES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  i2cm_item_t   item,
  output i2cm_result_t res
);

  logic [4:0] phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [3:0] recovery_count, recovery_count_next;
  logic [6:0] held_dev_addr, held_dev_addr_next;
  logic [7:0] held_reg_ptr, held_reg_ptr_next;
  logic [7:0] held_wr_data, held_wr_data_next;
  logic       held_final_ack, held_final_ack_next;
  logic [1:0] held_cmd, held_cmd_next;
  logic [2:0] held_status, held_status_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;

  always_comb begin
    logic       last;
    logic       ackbit;
    logic [3:0] rc_inc;
    phase_next          = phase;
    bit_count_next      = bit_count;
    shift_reg_next      = shift_reg;
    bytes_left_next     = bytes_left;
    recovery_count_next = recovery_count;
    held_dev_addr_next  = held_dev_addr;
    held_reg_ptr_next   = held_reg_ptr;
    held_wr_data_next   = held_wr_data;
    held_final_ack_next = held_final_ack;
    held_cmd_next       = held_cmd;
    held_status_next    = held_status;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    res                 = '0;
    last                = (held_cmd != CMD_BURST) || (bytes_left <= 8'd1);
    ackbit              = (held_cmd != CMD_BURST) ? held_final_ack : last;
    rc_inc              = recovery_count + 4'd1;

    // command latch on an idle tick
    if (phase == PH_IDLE && item.cmd != CMD_TICK) begin
      held_cmd_next       = item.cmd;
      held_dev_addr_next  = item.dev_addr;
      held_reg_ptr_next   = item.reg_ptr;
      held_wr_data_next   = item.wr_data;
      bytes_left_next     = item.burst_len;
      held_final_ack_next = item.final_ack_bit;
      held_status_next    = ST_OK;
      if (item.cmd == CMD_BURST && item.burst_len == 8'd0) begin
        held_status_next = ST_ZERO_LEN;
        res.done_res     = 1'b1;
        res.status       = ST_ZERO_LEN;
      end else begin
        phase_next     = PH_START;
        bit_count_next = 4'd0;
      end
    end

    case (phase_next)
      PH_START, PH_RSTART, PH_RECOV_START: begin
        if (bit_count_next == 4'd0) begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b1;
          bit_count_next = 4'd1;
        end else begin
          scl_level_next = 1'b1;
          sda_level_next = 1'b0;
          bit_count_next = 4'd0;
          if (phase_next == PH_START) begin
            phase_next     = PH_TX_ADDRW;
            shift_reg_next = {held_dev_addr_next, 1'b0};
          end else if (phase_next == PH_RSTART) begin
            phase_next     = PH_TX_ADDRR;
            shift_reg_next = {held_dev_addr_next, 1'b1};
          end else begin
            phase_next = PH_RECOV_STOP;
          end
        end
      end
      PH_TX_ADDRW, PH_TX_REG, PH_TX_DATA, PH_TX_ADDRR: begin
        scl_level_next = bit_count[0];
        sda_level_next = shift_reg[7];
        if (bit_count[0]) shift_reg_next = {shift_reg[6:0], 1'b0};
        if (bit_count == 4'd15) begin
          bit_count_next = 4'd0;
          phase_next     = phase + 5'd1;
        end else begin
          bit_count_next = bit_count + 4'd1;
        end
      end
      PH_ACK_ADDRW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDRR: begin
        scl_level_next = (bit_count != 4'd0);
        sda_level_next = 1'b1;
        if (bit_count < 4'd2) begin
          bit_count_next = bit_count + 4'd1;
        end else begin
          bit_count_next = 4'd0;
          if (item.sda_in) begin
            // slave nack: go clock the bus free
            phase_next          = PH_RECOV;
            recovery_count_next = 4'd0;
            case (phase)
              PH_ACK_ADDRW: held_status_next = ST_ADDRW_NAK;
              PH_ACK_REG:   held_status_next = ST_REG_NAK;
              PH_ACK_DATA:  held_status_next = ST_DATA_NAK;
              default:      held_status_next = ST_ADDRR_NAK;
            endcase
          end else begin
            case (phase)
              PH_ACK_ADDRW: begin
                phase_next     = PH_TX_REG;
                shift_reg_next = held_reg_ptr;
              end
              PH_ACK_REG: begin
                if (held_cmd == CMD_WRITE) begin
                  phase_next     = PH_TX_DATA;
                  shift_reg_next = held_wr_data;
                end else begin
                  phase_next = PH_RSTART;
                end
              end
              PH_ACK_DATA: phase_next = PH_STOP;
              default: begin
                phase_next     = PH_RX;
                shift_reg_next = 8'd0;
              end
            endcase
          end
        end
      end
      PH_RX: begin
        scl_level_next = bit_count[0];
        sda_level_next = 1'b1;
        if (bit_count[0]) shift_reg_next = {shift_reg[6:0], item.sda_in};
        if (bit_count == 4'd15) begin
          bit_count_next = 4'd0;
          phase_next     = PH_TX_ACK;
        end else begin
          bit_count_next = bit_count + 4'd1;
        end
      end
      PH_TX_ACK: begin
        sda_level_next = ackbit;
        if (bit_count == 4'd0) begin
          scl_level_next = 1'b0;
          bit_count_next = 4'd1;
        end else begin
          scl_level_next = 1'b1;
          bit_count_next = 4'd0;
          res.rx_valid   = 1'b1;
          res.rx_data    = shift_reg;
          res.rx_last    = last;
          if (last) begin
            phase_next = PH_STOP;
          end else begin
            bytes_left_next = bytes_left - 8'd1;
            phase_next      = PH_RX;
            shift_reg_next  = 8'd0;
          end
        end
      end
      PH_STOP, PH_RECOV_STOP: begin
        scl_level_next = 1'b1;
        if (bit_count == 4'd0) begin
          sda_level_next = 1'b0;
          bit_count_next = 4'd1;
        end else begin
          sda_level_next = 1'b1;
          bit_count_next = 4'd0;
          phase_next     = PH_IDLE;
          res.done_res   = 1'b1;
          res.status     = held_status;
        end
      end
      PH_RECOV: begin
        sda_level_next = 1'b1;
        if (bit_count == 4'd0) begin
          scl_level_next = 1'b1;
          bit_count_next = 4'd1;
        end else begin
          scl_level_next      = 1'b0;
          bit_count_next      = 4'd0;
          recovery_count_next = rc_inc;
          if (rc_inc >= 4'(RECOVERY_PULSES) || rc_inc == 4'd0) begin
            recovery_count_next = 4'd0;
            phase_next          = PH_RECOV_START;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    res.scl_out  = scl_level_next;
    res.sda_out  = sda_level_next;
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= 4'd0;
      shift_reg      <= 8'd0;
      bytes_left     <= 8'd0;
      recovery_count <= 4'd0;
      held_dev_addr  <= 7'd0;
      held_reg_ptr   <= 8'd0;
      held_wr_data   <= 8'd0;
      held_final_ack <= 1'b0;
      held_cmd       <= CMD_TICK;
      held_status    <= ST_OK;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
    end else if (step) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      shift_reg      <= shift_reg_next;
      bytes_left     <= bytes_left_next;
      recovery_count <= recovery_count_next;
      held_dev_addr  <= held_dev_addr_next;
      held_reg_ptr   <= held_reg_ptr_next;
      held_wr_data   <= held_wr_data_next;
      held_final_ack <= held_final_ack_next;
      held_cmd       <= held_cmd_next;
      held_status    <= held_status_next;
      scl_level      <= scl_level_next;
      sda_level      <= sda_level_next;
    end
  end

  // phase groups seen by the checks below
  logic in_ack, in_recov, nak_status;
  assign in_ack     = phase inside {PH_ACK_ADDRW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDRR};
  assign in_recov   = phase inside {PH_RECOV, PH_RECOV_START, PH_RECOV_STOP};
  assign nak_status = held_status inside {[ST_ADDRW_NAK:ST_DATA_NAK]};

  // ack phases keep the bit count within 0 to 2
  `ASSERT_IMPL(a_ack_len, in_ack, (bit_count <= 4'd2), "ack phase bit count out of range")
  // recovery only follows a slave nack
  `ASSERT_IMPL(a_recov_status, in_recov, nak_status, "recovery without nack status")
  // recovery pulse count stays below the limit
  `ASSERT_CLK(a_recov_cnt, (recovery_count < 4'(RECOVERY_PULSES)), "recovery count past limit")

endmodule

// ===== rtl/i2c_master_register_access.sv =====
// ---------------------------------------------------------------------------
// i2c_master_register_access
// i2c master for register write, single read and burst read, one bus tick
// per item
// ---------------------------------------------------------------------------
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+---------------------------------------
// s_       | in  | s_tvalid/s_tready  | s_tdata: command, addresses, sda sample
// m_       | out | m_tvalid/m_tready  | m_tdata: pin levels, rx byte, status;
//          |     |                    | m_tlast: final received byte
//
// one item in, one item out; a new item is taken every cycle unless m_tready stalls the output
// an item passes through the input register, then the sequencer step whose
// result lands in the output register
// the sequencer state loop (phase, bit counter, shift register) feeds its own
// registers directly, so the rate is one item per clock while the output does not stall
// rst is synchronous: sequencer goes idle with both lines released high
// a stall on m_tready holds the output item; an empty input register takes
// one more item, then s_tready drops; nothing is dropped or repeated

`include "assert_macros.svh"

module i2c_master_register_access import i2cm_pkg::*; #(
  parameter int RECOVERY_PULSES = RECOVERY_PULSES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd[1:0], dev_addr[8:2], reg_ptr[16:9], wr_data[24:17],
  // burst_len[32:25], final_ack_bit[33], sda_in[34], zero fill above
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // scl_out[0], sda_out[1], rx_valid[2], rx_data[10:3], done_res[11],
  // status[14:12], busy_res[15]
  output logic [15:0] m_tdata,
  output logic        m_tlast
);

  i2cm_item_t   in_item;
  logic         in_valid;
  logic         advance;
  i2cm_result_t step_res;
  i2cm_result_t out_res;
  logic         out_valid;

  // an item moves into the sequencer when the output slot is free or leaving
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd           <= s_tdata[1:0];
      in_item.dev_addr      <= s_tdata[8:2];
      in_item.reg_ptr       <= s_tdata[16:9];
      in_item.wr_data       <= s_tdata[24:17];
      in_item.burst_len     <= s_tdata[32:25];
      in_item.final_ack_bit <= s_tdata[33];
      in_item.sda_in        <= s_tdata[34];
    end
  end

  // sequencer: state registers advance once per item
  i2cm_seq #(
    .RECOVERY_PULSES(RECOVERY_PULSES)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .res  (step_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.rx_last;
  assign m_tdata  = {out_res.busy_res, out_res.status, out_res.done_res,
                     out_res.rx_data, out_res.rx_valid, out_res.sda_out,
                     out_res.scl_out};

  // a received byte and a finished transaction never share a tick
  `ASSERT_IMPL(a_rx_done_excl, out_valid, !(out_res.rx_valid && out_res.done_res), "rx on done")
  // the done tick always reports idle
  `ASSERT_IMPL(a_done_idle, (out_valid && out_res.done_res), !out_res.busy_res, "busy on done")
  // a step is only taken with an item in the input register
  `ASSERT_IMPL(a_step_item, advance, $past(s_tready) || in_valid, "step without an item")

endmodule
